### rtl/core/sdpc_pkg.sv
package sdpc_pkg;

  // Width of the wrapping millisecond time base
  localparam int unsigned TimeBits = 32;

  typedef logic [TimeBits-1:0] time_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgDebounceMs = 2'd0,
    CfgOffLevel   = 2'd1,
    CfgLongMs     = 2'd2,
    CfgShortMs    = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgDataBits = 16;

  // Register reset values
  localparam logic [15:0] DebounceMsRst = 16'd50;
  localparam logic        OffLevelRst   = 1'b1;
  localparam logic [15:0] LongMsRst     = 16'd1000;
  localparam logic [15:0] ShortMsRst    = 16'd500;

  // One input item: a raw pin poll
  typedef struct packed {
    logic        pin_sample;
    logic [31:0] now_ms;
    logic        clear_change;
  } in_item_t;

  // One result item, also the layout of the status flags
  typedef struct packed {
    logic switch_on;
    logic changed;
    logic stable;
    logic long_press;
    logic double_press;
  } out_item_t;

endpackage

### rtl/core/sdpc_in_if.sv
interface sdpc_in_if import sdpc_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sdpc_out_if.sv
interface sdpc_out_if import sdpc_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/switch_debounce_press_classifier.sv
// Path: an accepted item waits in the input register until the result register frees up
// (input register, then one pass of compare logic into the result register).
// Throughput: one item per cycle while the result side takes results; the only loop is the state update.
// Reset: registers return to their defaults, status flags and times clear,
// the last sample equals the default off level, and both stages empty.
module switch_debounce_press_classifier import sdpc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  sdpc_in_if.sink                item_i,
  sdpc_out_if.source             result_o
);

  // Configuration registers
  logic [15:0] debounce_q, long_q, short_q;
  logic        off_level_q;

  // Pipeline registers
  logic      in_valid_q, out_valid_q;
  in_item_t  in_q;
  out_item_t res_q, res_d;

  // Debounce state
  logic      last_sample_q, last_sample_d;
  out_item_t flags_q, flags_d, flags_nx;
  time_t     toggle_q, toggle_d;
  time_t     last_settle_q, last_settle_d;
  time_t     prior_settle_q, prior_settle_d;

  logic  out_free, advance, settle;
  time_t now_t, diff_tog, diff_last, diff_prior;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceMsRst;
      off_level_q <= OffLevelRst;
      long_q      <= LongMsRst;
      short_q     <= ShortMsRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgDebounceMs: debounce_q  <= cfg_wdata_i;
        CfgOffLevel:   off_level_q <= cfg_wdata_i[0];
        CfgLongMs:     long_q      <= cfg_wdata_i;
        CfgShortMs:    short_q     <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Handshake: the result register frees up when empty or being taken
  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && out_free;
  assign item_i.ready = !in_valid_q || out_free;

  assign result_o.valid = out_valid_q;
  assign result_o.data  = res_q;

  // Time differences, wrapping
  assign now_t      = time_t'(in_q.now_ms);
  assign diff_tog   = now_t - toggle_q;
  assign diff_last  = now_t - last_settle_q;
  assign diff_prior = now_t - prior_settle_q;

  assign settle = (in_q.pin_sample == last_sample_q) && !flags_q.stable &&
                  (diff_tog >= time_t'(debounce_q));

  // Next state and result for the item in the input register
  always_comb begin
    flags_nx       = flags_q;
    last_sample_d  = last_sample_q;
    toggle_d       = toggle_q;
    last_settle_d  = last_settle_q;
    prior_settle_d = prior_settle_q;
    if (in_q.pin_sample != last_sample_q) begin
      flags_nx.changed = 1'b0;
      flags_nx.stable  = 1'b0;
      last_sample_d    = in_q.pin_sample;
      toggle_d         = now_t;
    end else if (settle) begin
      flags_nx.switch_on    = (last_sample_q != off_level_q);
      flags_nx.changed      = 1'b1;
      flags_nx.stable       = 1'b1;
      flags_nx.long_press   = (diff_last > time_t'(long_q));
      flags_nx.double_press = (diff_prior < time_t'(short_q));
      prior_settle_d        = last_settle_q;
      last_settle_d         = now_t;
      toggle_d              = now_t;
    end
    res_d   = flags_nx;
    // Drop changed after the result when the item asks for it
    flags_d = flags_nx;
    if (in_q.clear_change) begin
      flags_d.changed = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      last_sample_q  <= OffLevelRst;
      flags_q        <= '0;
      toggle_q       <= '0;
      last_settle_q  <= '0;
      prior_settle_q <= '0;
    end else begin
      if (item_i.ready) begin
        in_valid_q <= item_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        last_sample_q  <= last_sample_d;
        flags_q        <= flags_d;
        toggle_q       <= toggle_d;
        last_settle_q  <= last_settle_d;
        prior_settle_q <= prior_settle_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q <= item_i.data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Changed is only ever raised together with stable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.changed |-> result_o.data.stable)
    else $error("changed reported without stable");

  // A toggling sample clears stable in the state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.pin_sample != last_sample_q) |=> !flags_q.stable)
    else $error("stable survived a sample toggle");

  // An item in the input register stays while the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("item lost in input register");

  // A settle records its timestamp and shifts the older one back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && settle |=> (last_settle_q == $past(now_t)) &&
                          (prior_settle_q == $past(last_settle_q)))
    else $error("settle times not recorded");

endmodule

### sim/tb_switch_debounce_press_classifier.sv
module tb_switch_debounce_press_classifier import sdpc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the debounced switch state and queues the flags each poll must return
  class press_tracker;
    logic [15:0] debounce;
    logic        off_lvl;
    logic [15:0] long_lim;
    logic [15:0] short_lim;
    logic        last_pin;
    out_item_t   flags;
    time_t       toggle_at;
    time_t       settle_at;
    time_t       prior_at;
    out_item_t   flags_due[$];
    int unsigned errors;

    function new();
      debounce  = DebounceMsRst;
      off_lvl   = OffLevelRst;
      long_lim  = LongMsRst;
      short_lim = ShortMsRst;
      last_pin  = OffLevelRst;
      flags     = '0;
      toggle_at = '0;
      settle_at = '0;
      prior_at  = '0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] value);
      case (idx)
        CfgDebounceMs: debounce  = value;
        CfgOffLevel:   off_lvl   = value[0];
        CfgLongMs:     long_lim  = value;
        CfgShortMs:    short_lim = value;
        default: ;
      endcase
    endfunction

    // Advance the debouncer by one accepted poll and queue its flags
    function void note_poll(in_item_t poll);
      time_t since_toggle;
      time_t since_settle;
      time_t since_prior;
      since_toggle = poll.now_ms - toggle_at;
      since_settle = poll.now_ms - settle_at;
      since_prior  = poll.now_ms - prior_at;
      if (poll.pin_sample != last_pin) begin
        // Restart the debounce window; keep the level and press flags
        flags.changed = 1'b0;
        flags.stable  = 1'b0;
        last_pin      = poll.pin_sample;
        toggle_at     = poll.now_ms;
      end else if (!flags.stable) begin
        if (since_toggle >= time_t'(debounce)) begin
          // Settle: recompute level and press classification
          flags              = '0;
          flags.switch_on    = (last_pin != off_lvl);
          flags.changed      = 1'b1;
          flags.stable       = 1'b1;
          flags.long_press   = (since_settle > time_t'(long_lim));
          flags.double_press = (since_prior < time_t'(short_lim));
          prior_at           = settle_at;
          settle_at          = poll.now_ms;
          toggle_at          = poll.now_ms;
        end
      end
      flags_due.push_back(flags);
      // The acknowledge only takes effect after this result
      if (poll.clear_change) flags.changed = 1'b0;
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (want !== got) begin
        $error("%s mismatch: expected %0b, actual %0b", name, want, got);
        errors++;
      end
    endfunction

    function void check_flags(out_item_t got);
      out_item_t want;
      if (flags_due.size() == 0) begin
        $error("result with no poll outstanding: %b", got);
        errors++;
        return;
      end
      want = flags_due.pop_front();
      compare_field("switch_on", want.switch_on, got.switch_on);
      compare_field("changed", want.changed, got.changed);
      compare_field("stable", want.stable, got.stable);
      compare_field("long_press", want.long_press, got.long_press);
      compare_field("double_press", want.double_press, got.double_press);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [1:0]             cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;

  sdpc_in_if  poll_if ();
  sdpc_out_if flag_if ();

  switch_debounce_press_classifier i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (poll_if),
    .result_o    (flag_if)
  );

  press_tracker tracker = new();

  bit    idle_on;
  bit    hold_off_req;
  logic  pin_now;
  time_t poll_ms;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up after a generous bound on the slowest correct run
  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, 6) : 0;
  endfunction

  // Offer one poll, hold it until accepted, then predict its flags
  task automatic send_poll(logic pin, time_t stamp, logic clr);
    in_item_t    poll;
    int unsigned gap;
    poll.pin_sample   = pin;
    poll.now_ms       = stamp;
    poll.clear_change = clr;
    gap = draw_gap();
    if (gap > 0) begin
      poll_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    poll_if.valid <= 1'b1;
    poll_if.data  <= poll;
    do @(posedge clk_i); while (!poll_if.ready);
    tracker.note_poll(poll);
    pin_now = pin;
  endtask

  // Stop offering and wait until every poll has returned its flags
  task automatic wait_for_results();
    poll_if.valid <= 1'b0;
    while (tracker.flags_due.size() != 0) @(posedge clk_i);
  endtask

  // Write all four registers back to back while the block is idle
  task automatic program_regs(logic [15:0] deb, logic off, logic [15:0] lng,
                              logic [15:0] shrt);
    logic [15:0] vals [4];
    cfg_reg_e    idx;
    wait_for_results();
    repeat (4) @(posedge clk_i);
    vals[CfgDebounceMs] = deb;
    vals[CfgOffLevel]   = {15'($urandom), off};
    vals[CfgLongMs]     = lng;
    vals[CfgShortMs]    = shrt;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_e'(i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      tracker.set_reg(idx, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mix of clean holds around the thresholds, contact bounce and raw noise
  task automatic run_phase(int unsigned count);
    int unsigned done_n;
    int unsigned span;
    int unsigned step;
    int unsigned polls;
    int unsigned deb;
    int unsigned lng;
    int unsigned shrt;
    logic        pin;
    done_n = 0;
    while (done_n < count) begin
      deb  = 32'(tracker.debounce);
      lng  = 32'(tracker.long_lim);
      shrt = 32'(tracker.short_lim);
      case ($urandom_range(0, 9))
        0: begin
          poll_ms = $urandom;
          send_poll(1'($urandom_range(0, 1)), poll_ms, 1'($urandom_range(0, 1)));
          done_n++;
        end
        1: begin
          repeat ($urandom_range(2, 5)) begin
            poll_ms += $urandom_range(0, 1 + deb / 4);
            send_poll(~pin_now, poll_ms, 1'($urandom_range(0, 1)));
            done_n++;
          end
        end
        default: begin
          pin = ($urandom_range(0, 3) == 0) ? pin_now : ~pin_now;
          case ($urandom_range(0, 5))
            0: span = $urandom_range(0, deb);
            1: span = deb + $urandom_range(0, 2);
            2: span = (lng == 0) ? 0 : lng - 1 + $urandom_range(0, 2);
            3: span = (shrt == 0) ? 0 : shrt - 1 + $urandom_range(0, 2);
            4: span = $urandom_range(0, 2 * lng + 2 * deb + 10);
            default: span = $urandom_range(0, 100);
          endcase
          polls = $urandom_range(2, 5);
          step  = span / (polls - 1);
          poll_ms += $urandom_range(1, 20);
          for (int i = 0; i < polls; i++) begin
            if (i > 0) poll_ms += (i == polls - 1) ? span - step * (polls - 2) : step;
            send_poll(pin, poll_ms, $urandom_range(0, 2) == 0);
          end
          done_n += polls;
        end
      endcase
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    flag_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        flag_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          flag_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      flag_if.ready <= 1'b1;
      do @(posedge clk_i); while (!flag_if.valid);
      tracker.check_flags(flag_if.data);
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgDebounceMs;
    cfg_wdata_i   <= '0;
    poll_if.valid <= 1'b0;
    poll_if.data  <= '0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    pin_now      = OffLevelRst;
    poll_ms      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk at reset settings: thresholds hit exactly, bounce, wrap
    send_poll(1'b1, 32'd0, 1'b0);
    send_poll(1'b1, 32'd49, 1'b0);
    send_poll(1'b1, 32'd50, 1'b0);
    send_poll(1'b1, 32'd60, 1'b1);
    send_poll(1'b1, 32'd70, 1'b0);
    send_poll(1'b0, 32'd100, 1'b0);
    send_poll(1'b0, 32'd149, 1'b0);
    send_poll(1'b0, 32'd1050, 1'b0);
    send_poll(1'b1, 32'd1100, 1'b0);
    send_poll(1'b1, 32'd2051, 1'b0);
    send_poll(1'b0, 32'd2060, 1'b1);
    send_poll(1'b0, 32'd2110, 1'b0);
    send_poll(1'b1, 32'd2120, 1'b0);
    send_poll(1'b1, 32'd2170, 1'b0);
    send_poll(1'b0, 32'd2180, 1'b0);
    send_poll(1'b0, 32'd2230, 1'b1);
    send_poll(1'b1, 32'd2600, 1'b0);
    send_poll(1'b1, 32'd2670, 1'b0);
    send_poll(1'b0, 32'd2680, 1'b0);
    send_poll(1'b1, 32'd2690, 1'b1);
    send_poll(1'b0, 32'hFFFF_FFF0, 1'b0);
    send_poll(1'b0, 32'h0000_0030, 1'b0);
    send_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_poll(1'b1, 32'h0000_0031, 1'b0);
    poll_ms = 32'h0000_0031;
    run_phase(180);

    // Extremes, then random settings; some phases run without idling
    program_regs(16'd0, 1'b0, 16'd0, 16'd0);
    run_phase(180);
    program_regs(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    idle_on = 1'b0;
    run_phase(180);
    for (int ph = 3; ph < 9; ph++) begin
      if ($urandom_range(0, 3) == 0)
        program_regs(16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom),
                     16'($urandom));
      else
        program_regs(16'($urandom_range(0, 100)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1500)));
      idle_on = (ph % 3 != 2);
      if (ph == 4) hold_off_req = 1'b1;
      if (ph == 5) begin
        run_phase(90);
        wait_for_results();
        run_phase(90);
      end else begin
        run_phase(180);
      end
    end

    // Drain and let the pipeline settle before judging
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### sim.f
rtl/core/sdpc_pkg.sv
rtl/core/sdpc_in_if.sv
rtl/core/sdpc_out_if.sv
rtl/core/switch_debounce_press_classifier.sv
sim/tb_switch_debounce_press_classifier.sv
